@@ rtl/core/sstf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Shared types and fixed constants of the shortest-seek-time-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    // Width of the running seek total, which saturates at its maximum.
    localparam int TOTAL_W = 16;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } sched_state_t;

    // Control that goes with each word streamed out of the request memory.
    typedef struct packed {
        logic start;
        logic sample;
        logic skip;
    } scan_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/sstf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSTF scheduler channels
// Valid/ready channels for configuration, incoming requests and results.
// ----------------------------------------------------------------------------
interface sstf_cfg_if #(
    parameter int CYLINDER_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [CYLINDER_BITS-1:0] head_start;

    modport source (output valid, output head_start, input ready);
    modport sink   (input valid, input head_start, output ready);
endinterface

interface sstf_req_if #(
    parameter int CYLINDER_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [CYLINDER_BITS-1:0] cylinder;
    logic                     is_last;

    modport source (output valid, output cylinder, output is_last, input ready);
    modport sink   (input valid, input cylinder, input is_last, output ready);
endinterface

interface sstf_res_if import sstf_pkg::*; #(
    parameter int CYLINDER_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [CYLINDER_BITS-1:0] served_cylinder;
    logic [CYLINDER_BITS-1:0] seek_distance;
    logic [TOTAL_W-1:0]       total_distance;
    logic                     last;

    modport source (output valid, output served_cylinder, output seek_distance,
                    output total_distance, output last, input ready);
    modport sink   (input valid, input served_cylinder, input seek_distance,
                    input total_distance, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sstf_req_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSTF request memory
// Single-port-write, single-port-read store with registered read data.
// ----------------------------------------------------------------------------
module sstf_req_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 12,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/sstf_nearest.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSTF nearest-request tracker
// Keeps the closest unserved request seen so far during one memory scan.
// ----------------------------------------------------------------------------
module sstf_nearest import sstf_pkg::*; #(
    parameter int CYLINDER_BITS = 12,
    parameter int IDX_W         = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire scan_ctl_t                ctl,
    input  wire logic [IDX_W-1:0]         idx,
    input  wire logic [CYLINDER_BITS-1:0] cyl,
    input  wire logic [CYLINDER_BITS-1:0] head,
    output logic      [IDX_W-1:0]         best_idx,
    output logic      [CYLINDER_BITS-1:0] best_cyl,
    output logic      [CYLINDER_BITS-1:0] best_dist
);

    logic                     found_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [CYLINDER_BITS-1:0] best_cyl_reg;
    logic [CYLINDER_BITS-1:0] best_dist_reg;
    logic [CYLINDER_BITS-1:0] gap;
    logic                     take;

    assign gap = (cyl >= head) ? (cyl - head) : (head - cyl);

    // Ties go to the lower cylinder; equal cylinders keep the earlier entry.
    assign take = ctl.sample && !ctl.skip &&
                  (!found_reg || (gap < best_dist_reg) ||
                   ((gap == best_dist_reg) && (cyl < best_cyl_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !ctl.start)
        begin
            best_idx_reg  <= idx;
            best_cyl_reg  <= cyl;
            best_dist_reg <= gap;
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_cyl  = best_cyl_reg;
    assign best_dist = best_dist_reg;

endmodule
`default_nettype wire

@@ rtl/core/sstf_disk_scheduler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSTF disk scheduler
// Collects a batch of cylinder requests and services them nearest first.
// ----------------------------------------------------------------------------
//  Channel | Dir | Carries
//  --------+-----+---------------------------------------------------------
//  cfg     | in  | head_start, the head position at the start of a batch
//  req     | in  | cylinder, is_last (one request per cycle while loading)
//  res     | out | served_cylinder, seek_distance, total_distance, last
//
//  Loading takes one request a cycle. After the request flagged is_last,
//  each result takes a scan of every stored request through the single read
//  port of the request memory, a drain state for the registered read data
//  and an emit state that commits it. No request is taken while scheduling.
//  Results wait in an output register; a stalled result holds the scan.
//  Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_top import sstf_pkg::*; #(
    parameter int MAX_REQUESTS  = 16,
    parameter int CYLINDER_BITS = 12
) (
    input wire logic clk,
    input wire logic rst_n,
    sstf_cfg_if.sink   cfg,
    sstf_req_if.sink   req,
    sstf_res_if.source res
);

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    sched_state_t state_reg, state_next;

    logic [CYLINDER_BITS-1:0] head_start_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         step_reg;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic [MAX_REQUESTS-1:0]  mask_reg;
    logic [CYLINDER_BITS-1:0] head_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     sample_reg;
    logic [IDX_W-1:0]         samp_idx_reg;

    logic                     res_valid_reg;
    logic [CYLINDER_BITS-1:0] res_cyl_reg;
    logic [CYLINDER_BITS-1:0] res_dist_reg;
    logic [TOTAL_W-1:0]       res_total_reg;
    logic                     res_last_reg;

    logic                     req_ready;
    logic                     rd_en;
    logic                     emit;
    logic                     scan_clear;
    logic                     req_fire;
    logic                     has_room;
    logic                     scan_last;
    logic                     res_free;
    logic                     final_step;
    logic [CYLINDER_BITS-1:0] rd_data;
    logic [IDX_W-1:0]         best_idx;
    logic [CYLINDER_BITS-1:0] best_cyl;
    logic [CYLINDER_BITS-1:0] best_dist;
    logic [TOTAL_W:0]         total_sum;
    logic [TOTAL_W-1:0]       total_sat;
    scan_ctl_t                scan_ctl;

    assign req_fire   = req.valid && req_ready;
    assign has_room   = count_reg < CNT_W'(MAX_REQUESTS);
    assign scan_last  = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg;
    assign res_free   = !res_valid_reg || res.ready;
    assign final_step = (step_reg + CNT_W'(1)) == count_reg;
    assign total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(best_dist);
    assign total_sat  = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

    // Configuration is always accepted.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_start_reg <= '0;
        end
        else if (cfg.valid)
        begin
            head_start_reg <= cfg.head_start;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (req_fire && req.is_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (res_free)
                begin
                    state_next = final_step ? ST_LOAD : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        rd_en      = 1'b0;
        emit       = 1'b0;
        scan_clear = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                req_ready = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en      = 1'b1;
                scan_clear = 1'b0;
            end
            ST_DRAIN:
            begin
                scan_clear = 1'b0;
            end
            ST_EMIT:
            begin
                emit = res_free;
            end
            default:
            begin
                scan_clear = 1'b1;
            end
        endcase
    end

    assign req.ready = req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            step_reg     <= '0;
            scan_idx_reg <= '0;
            mask_reg     <= '0;
            head_reg     <= '0;
            total_reg    <= '0;
            sample_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sample_reg <= rd_en;

            if (rd_en)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            else
            begin
                scan_idx_reg <= '0;
            end

            if (req_fire)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (req.is_last)
                begin
                    head_reg  <= head_start_reg;
                    total_reg <= '0;
                    mask_reg  <= '0;
                    step_reg  <= '0;
                end
            end
            else if (emit)
            begin
                mask_reg[best_idx] <= 1'b1;
                head_reg           <= best_cyl;
                total_reg          <= total_sat;
                step_reg           <= step_reg + CNT_W'(1);
                if (final_step)
                begin
                    count_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            samp_idx_reg <= scan_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Request store and nearest-request search
    // ------------------------------------------------------------------
    sstf_req_mem #(
        .DEPTH  (MAX_REQUESTS),
        .WIDTH  (CYLINDER_BITS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (req_fire && has_room),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (req.cylinder),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    assign scan_ctl.start  = scan_clear;
    assign scan_ctl.sample = sample_reg;
    assign scan_ctl.skip   = mask_reg[samp_idx_reg];

    sstf_nearest #(
        .CYLINDER_BITS (CYLINDER_BITS),
        .IDX_W         (IDX_W)
    ) u_nearest (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .idx       (samp_idx_reg),
        .cyl       (rd_data),
        .head      (head_reg),
        .best_idx  (best_idx),
        .best_cyl  (best_cyl),
        .best_dist (best_dist)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_cyl_reg   <= best_cyl;
            res_dist_reg  <= best_dist;
            res_total_reg <= total_sat;
            res_last_reg  <= final_step;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.served_cylinder = res_cyl_reg;
    assign res.seek_distance   = res_dist_reg;
    assign res.total_distance  = res_total_reg;
    assign res.last            = res_last_reg;

endmodule
`default_nettype wire
